@@ src/ltd_pkg.sv @@
// ----------------------------------------------------------------------------
// ltd_pkg
// Shared types and codes of the link tree traversal block.
// ----------------------------------------------------------------------------
`default_nettype none
package ltd_pkg;

  localparam int LINK_W   = 6;
  localparam int CNT_W    = 7;
  localparam int STATUS_W = 3;
  localparam int OFS_W    = 9;
  localparam int SIZE_W   = 3;

  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_SELF     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BAD_BASE = 3'd4;
  localparam logic [STATUS_W-1:0] ST_NOT_TREE = 3'd5;

  localparam logic OP_ADD      = 1'b0;
  localparam logic OP_TRAVERSE = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP,
    S_LOAD,
    S_SCAN,
    S_EMIT,
    S_FAIL
  } ltd_state_e;

  typedef struct packed {
    logic add;
    logic start_trav;
    logic bad_base;
    logic pop;
    logic load;
    logic scan_step;
    logic emit_step;
    logic fail;
  } ltd_cmd_t;

  typedef struct packed {
    logic base_bad;
    logic scan_done;
    logic not_tree;
    logic top_zero;
    logic emit_done;
  } ltd_sts_t;

endpackage
`default_nettype wire

@@ src/ltd_ram.sv @@
// ----------------------------------------------------------------------------
// ltd_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module ltd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   we_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                       wdata_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

@@ src/ltd_ctrl.sv @@
// ----------------------------------------------------------------------------
// ltd_ctrl
// Sequencer of the block: add, pop, joint scan, record emission and failure.
// ----------------------------------------------------------------------------
`default_nettype none
module ltd_ctrl
  import ltd_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start_i,
  input  wire logic     op_i,
  input  wire ltd_sts_t sts_i,
  output logic          busy_o,
  output ltd_cmd_t      cmd_o
);

  ltd_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = (state_q != S_IDLE);
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          if (op_i == OP_ADD) begin
            cmd_o.add = 1'b1;
          end else if (sts_i.base_bad) begin
            cmd_o.bad_base = 1'b1;
          end else begin
            cmd_o.start_trav = 1'b1;
            state_d = S_POP;
          end
        end
      end
      S_POP: begin
        cmd_o.pop = 1'b1;
        state_d = S_LOAD;
      end
      S_LOAD: begin
        cmd_o.load = 1'b1;
        state_d = S_SCAN;
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.not_tree) begin
          state_d = S_FAIL;
        end else if (sts_i.scan_done) begin
          state_d = sts_i.top_zero ? S_EMIT : S_POP;
        end
      end
      S_EMIT: begin
        cmd_o.emit_step = 1'b1;
        if (sts_i.emit_done) begin
          state_d = S_IDLE;
        end
      end
      S_FAIL: begin
        cmd_o.fail = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ src/ltd_dp.sv @@
// ----------------------------------------------------------------------------
// ltd_dp
// Datapath: joint table, traversal stack, record buffer, counters, outputs.
// ----------------------------------------------------------------------------
`default_nettype none
module ltd_dp
  import ltd_pkg::*;
#(
  parameter int MAX_LINKS  = 64,
  parameter int MAX_JOINTS = 64
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire ltd_cmd_t            cmd_i,
  output ltd_sts_t                 sts_o,
  input  wire logic                cfg_we_i,
  input  wire logic [CNT_W-1:0]    cfg_data_i,
  input  wire logic [LINK_W-1:0]   first_link_i,
  input  wire logic [LINK_W-1:0]   second_link_i,
  input  wire logic [SIZE_W-1:0]   joint_pos_coords_i,
  input  wire logic [SIZE_W-1:0]   joint_dofs_i,
  input  wire logic [LINK_W-1:0]   base_link_i,
  output logic                     result_valid_o,
  output logic [STATUS_W-1:0]      status_o,
  output logic [LINK_W-1:0]        joint_index_o,
  output logic [OFS_W-1:0]         pos_offset_o,
  output logic [OFS_W-1:0]         dof_offset_o,
  output logic [LINK_W-1:0]        slot_o,
  output logic [LINK_W-1:0]        link_out_o,
  output logic [LINK_W-1:0]        parent_link_o,
  output logic [LINK_W-1:0]        parent_joint_o,
  output logic                     is_base_o,
  output logic                     last_o
);

  localparam int JAW = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
  localparam int JCW = $clog2(MAX_JOINTS + 1);
  localparam int LAW = $clog2(MAX_LINKS);
  localparam int LCW = $clog2(MAX_LINKS + 1);
  localparam int PAR_W = LINK_W + 1;
  localparam int STK_W = LINK_W + PAR_W;
  localparam int REC_W = 3 * LINK_W;
  localparam logic [CNT_W-1:0] NLIM = CNT_W'(MAX_LINKS);
  localparam logic [JCW-1:0]   JLIM = JCW'(MAX_JOINTS);

  logic [CNT_W-1:0] link_count_q;
  logic [CNT_W-1:0] n_eff;
  logic [JCW-1:0]   stored_q;
  logic [OFS_W-1:0] pos_total_q, dof_total_q;
  logic [LCW-1:0]   top_q, rec_q, k_q, slot_q;
  logic [JCW-1:0]   j_q;
  logic [JAW-1:0]   jprev_q;
  logic             pv_q, ev_q;
  logic [LINK_W-1:0] cur_q;
  logic [PAR_W-1:0]  par_q;

  logic             add_range, add_self, add_full, add_ok;
  logic             j_we;
  logic [JAW-1:0]   j_addr;
  logic [2*LINK_W-1:0] j_rd;
  logic [LINK_W-1:0] ja, jb, nb;
  logic             hit, skip, take, issue;
  logic             s_we;
  logic [LAW-1:0]   s_waddr, s_raddr;
  logic [STK_W-1:0] s_wdata, s_rd;
  logic             r_we;
  logic [LAW-1:0]   r_waddr;
  logic [REC_W-1:0] r_wdata, r_rd;
  logic             emit_issue;

  assign n_eff     = (link_count_q > NLIM) ? NLIM : link_count_q;
  assign add_range = ({1'b0, first_link_i} >= n_eff) || ({1'b0, second_link_i} >= n_eff);
  assign add_self  = (first_link_i == second_link_i);
  assign add_full  = (stored_q >= JLIM);
  assign add_ok    = !add_range && !add_self && !add_full;

  assign j_we   = cmd_i.add && add_ok;
  assign j_addr = cmd_i.add ? stored_q[JAW-1:0] : j_q[JAW-1:0];
  assign issue  = cmd_i.scan_step && (j_q < stored_q);

  ltd_ram #(.WIDTH(2*LINK_W), .DEPTH(MAX_JOINTS)) u_joint_ram (
    .clk_i   (clk_i),
    .we_i    (j_we),
    .waddr_i (j_addr),
    .wdata_i ({first_link_i, second_link_i}),
    .raddr_i (j_addr),
    .rdata_o (j_rd)
  );

  assign ja   = j_rd[2*LINK_W-1:LINK_W];
  assign jb   = j_rd[LINK_W-1:0];
  assign nb   = (ja == cur_q) ? jb : ja;
  assign hit  = (ja == cur_q) || (jb == cur_q);
  assign skip = !par_q[LINK_W] && (nb == par_q[LINK_W-1:0]);
  assign take = cmd_i.scan_step && pv_q && hit && !skip;

  assign sts_o.base_bad  = ({1'b0, base_link_i} >= n_eff);
  assign sts_o.not_tree  = take && (CNT_W'(rec_q) >= n_eff);
  assign sts_o.scan_done = !pv_q && (j_q >= stored_q);
  assign sts_o.top_zero  = (top_q == '0);
  assign sts_o.emit_done = !ev_q && (k_q >= rec_q);

  assign s_we    = cmd_i.start_trav || (take && !sts_o.not_tree);
  assign s_waddr = cmd_i.start_trav ? '0 : top_q[LAW-1:0];
  assign s_wdata = cmd_i.start_trav ? {base_link_i, 1'b1, {LINK_W{1'b0}}}
                                    : {nb, 1'b0, cur_q};
  assign s_raddr = LAW'(top_q - LCW'(1));

  ltd_ram #(.WIDTH(STK_W), .DEPTH(MAX_LINKS)) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (s_waddr),
    .wdata_i (s_wdata),
    .raddr_i (s_raddr),
    .rdata_o (s_rd)
  );

  assign r_we    = s_we;
  assign r_waddr = cmd_i.start_trav ? '0 : rec_q[LAW-1:0];
  assign r_wdata = cmd_i.start_trav ? {base_link_i, {(2*LINK_W){1'b0}}}
                                    : {nb, cur_q, LINK_W'(jprev_q)};
  assign emit_issue = cmd_i.emit_step && (k_q < rec_q);

  ltd_ram #(.WIDTH(REC_W), .DEPTH(MAX_LINKS)) u_record_ram (
    .clk_i   (clk_i),
    .we_i    (r_we),
    .waddr_i (r_waddr),
    .wdata_i (r_wdata),
    .raddr_i (k_q[LAW-1:0]),
    .rdata_o (r_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_count_q   <= '0;
      stored_q       <= '0;
      pos_total_q    <= '0;
      dof_total_q    <= '0;
      top_q          <= '0;
      rec_q          <= '0;
      k_q            <= '0;
      j_q            <= '0;
      pv_q           <= 1'b0;
      ev_q           <= 1'b0;
      result_valid_o <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        link_count_q <= cfg_data_i;
      end
      if (j_we) begin
        stored_q    <= stored_q + JCW'(1);
        pos_total_q <= pos_total_q + OFS_W'(joint_pos_coords_i);
        dof_total_q <= dof_total_q + OFS_W'(joint_dofs_i);
      end
      if (cmd_i.start_trav) begin
        top_q <= LCW'(1);
        rec_q <= LCW'(1);
        k_q   <= '0;
      end else if (cmd_i.pop) begin
        top_q <= top_q - LCW'(1);
      end else if (take && !sts_o.not_tree) begin
        top_q <= top_q + LCW'(1);
        rec_q <= rec_q + LCW'(1);
      end
      if (cmd_i.load) begin
        j_q  <= '0;
        pv_q <= 1'b0;
      end else if (cmd_i.scan_step) begin
        pv_q <= issue;
        if (issue) begin
          j_q <= j_q + JCW'(1);
        end
      end
      ev_q <= emit_issue;
      if (emit_issue) begin
        k_q <= k_q + LCW'(1);
      end
      result_valid_o <= cmd_i.add || cmd_i.bad_base || cmd_i.fail || ev_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      jprev_q <= j_q[JAW-1:0];
    end
    if (cmd_i.load) begin
      cur_q <= s_rd[STK_W-1:PAR_W];
      par_q <= s_rd[PAR_W-1:0];
    end
    slot_q <= k_q;
    status_o       <= ST_OK;
    joint_index_o  <= '0;
    pos_offset_o   <= '0;
    dof_offset_o   <= '0;
    slot_o         <= '0;
    link_out_o     <= '0;
    parent_link_o  <= '0;
    parent_joint_o <= '0;
    is_base_o      <= 1'b0;
    last_o         <= 1'b1;
    if (cmd_i.add) begin
      if (add_range) begin
        status_o <= ST_RANGE;
      end else if (add_self) begin
        status_o <= ST_SELF;
      end else if (add_full) begin
        status_o <= ST_FULL;
      end else begin
        joint_index_o <= LINK_W'(stored_q);
        pos_offset_o  <= pos_total_q;
        dof_offset_o  <= dof_total_q;
      end
    end else if (cmd_i.bad_base) begin
      status_o <= ST_BAD_BASE;
    end else if (cmd_i.fail) begin
      status_o <= ST_NOT_TREE;
    end else if (ev_q) begin
      slot_o         <= LINK_W'(slot_q);
      link_out_o     <= r_rd[REC_W-1:2*LINK_W];
      parent_link_o  <= r_rd[2*LINK_W-1:LINK_W];
      parent_joint_o <= r_rd[LINK_W-1:0];
      is_base_o      <= (slot_q == '0);
      last_o         <= (slot_q == rec_q - LCW'(1));
    end
  end

endmodule
`default_nettype wire

@@ src/link_tree_dfs_traversal.sv @@
// ----------------------------------------------------------------------------
// link_tree_dfs_traversal
// Joint table with depth-first traversal of the link tree it describes.
// ----------------------------------------------------------------------------
// An add-joint item gives its result on the next cycle. A traversal pops
// each link from the stack (states S_POP, then S_LOAD), scans the whole
// joint table through the joint RAM read port, then plays back the buffered
// records, one per cycle. Records are buffered so a traversal that hits a
// cycle returns only its not-a-tree status. Results carry result_valid_o for
// a single cycle and cannot be stalled; busy_o is low from the cycle that
// carries the result of an add, a bad base or a not-a-tree stop, and from
// the cycle after the final record of a walk.
// ----------------------------------------------------------------------------
`default_nettype none
module link_tree_dfs_traversal
  import ltd_pkg::*;
#(
  parameter int MAX_LINKS  = 64,
  parameter int MAX_JOINTS = 64
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CNT_W-1:0]    cfg_data_i,
  input  wire logic                start_i,
  output logic                     busy_o,
  input  wire logic                op_i,
  input  wire logic [LINK_W-1:0]   first_link_i,
  input  wire logic [LINK_W-1:0]   second_link_i,
  input  wire logic [SIZE_W-1:0]   joint_pos_coords_i,
  input  wire logic [SIZE_W-1:0]   joint_dofs_i,
  input  wire logic [LINK_W-1:0]   base_link_i,
  output logic                     result_valid_o,
  output logic [STATUS_W-1:0]      status_o,
  output logic [LINK_W-1:0]        joint_index_o,
  output logic [OFS_W-1:0]         pos_offset_o,
  output logic [OFS_W-1:0]         dof_offset_o,
  output logic [LINK_W-1:0]        slot_o,
  output logic [LINK_W-1:0]        link_out_o,
  output logic [LINK_W-1:0]        parent_link_o,
  output logic [LINK_W-1:0]        parent_joint_o,
  output logic                     is_base_o,
  output logic                     last_o
);

  ltd_cmd_t cmd;
  ltd_sts_t sts;

  assign cfg_ready_o = 1'b1;

  ltd_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .op_i    (op_i),
    .sts_i   (sts),
    .busy_o  (busy_o),
    .cmd_o   (cmd)
  );

  ltd_dp #(.MAX_LINKS(MAX_LINKS), .MAX_JOINTS(MAX_JOINTS)) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .cfg_we_i           (cfg_valid_i && cfg_ready_o),
    .cfg_data_i         (cfg_data_i),
    .first_link_i       (first_link_i),
    .second_link_i      (second_link_i),
    .joint_pos_coords_i (joint_pos_coords_i),
    .joint_dofs_i       (joint_dofs_i),
    .base_link_i        (base_link_i),
    .result_valid_o     (result_valid_o),
    .status_o           (status_o),
    .joint_index_o      (joint_index_o),
    .pos_offset_o       (pos_offset_o),
    .dof_offset_o       (dof_offset_o),
    .slot_o             (slot_o),
    .link_out_o         (link_out_o),
    .parent_link_o      (parent_link_o),
    .parent_joint_o     (parent_joint_o),
    .is_base_o          (is_base_o),
    .last_o             (last_o)
  );

endmodule
`default_nettype wire

@@ tb/sv/tb_link_tree_dfs_traversal.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_link_tree_dfs_traversal
// Self-checking bench for the joint table and depth-first link walk: it grows
// a link tree through add-joint commands, walks it from random base links
// under several link counts, then closes a loop and fills the table. Every
// record is checked against a scoreboard that mirrors the table and the walk.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_link_tree_dfs_traversal;
  import ltd_pkg::*;

  localparam int WATCHDOG_LIMIT = 60000;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [LINK_W-1:0]   joint_index;
    logic [OFS_W-1:0]    pos_offset;
    logic [OFS_W-1:0]    dof_offset;
    logic [LINK_W-1:0]   slot;
    logic [LINK_W-1:0]   link_out;
    logic [LINK_W-1:0]   parent_link;
    logic [LINK_W-1:0]   parent_joint;
    logic                is_base;
    logic                last;
  } record_t;

  class walk_scoreboard;
    logic [CNT_W-1:0]  link_count;
    logic [LINK_W-1:0] end_a[64];
    logic [LINK_W-1:0] end_b[64];
    int                joints_stored;
    logic [OFS_W-1:0]  pos_total;
    logic [OFS_W-1:0]  dof_total;
    record_t           expected_records[$];
    int                errors;

    function new();
      link_count = '0;
      joints_stored = 0;
      pos_total = '0;
      dof_total = '0;
      errors = 0;
    endfunction

    function int links_present();
      return (link_count > 64) ? 64 : int'(link_count);
    endfunction

    function void enqueue(record_t r);
      expected_records.insert(expected_records.size(), r);
    endfunction

    function record_t status_only(logic [STATUS_W-1:0] st);
      record_t r;
      r = '0;
      r.status = st;
      r.last = 1'b1;
      return r;
    endfunction

    // returns 1 when the joint was stored
    function bit record_add(logic [LINK_W-1:0] a, logic [LINK_W-1:0] b,
                            logic [SIZE_W-1:0] np, logic [SIZE_W-1:0] nd);
      record_t r;
      int n;
      n = links_present();
      if (a >= n || b >= n) begin
        enqueue(status_only(ST_RANGE));
        return 0;
      end
      if (a == b) begin
        enqueue(status_only(ST_SELF));
        return 0;
      end
      if (joints_stored >= 64) begin
        enqueue(status_only(ST_FULL));
        return 0;
      end
      r = '0;
      r.status = ST_OK;
      r.joint_index = joints_stored[LINK_W-1:0];
      r.pos_offset = pos_total;
      r.dof_offset = dof_total;
      r.last = 1'b1;
      enqueue(r);
      end_a[joints_stored] = a;
      end_b[joints_stored] = b;
      pos_total = pos_total + OFS_W'(np);
      dof_total = dof_total + OFS_W'(nd);
      joints_stored++;
      return 1;
    endfunction

    function void record_walk(logic [LINK_W-1:0] base);
      record_t walk[$];
      record_t r;
      int stk_link[64];
      int stk_par[64];
      int top, n, cur, par, nb;
      n = links_present();
      if (base >= n) begin
        enqueue(status_only(ST_BAD_BASE));
        return;
      end
      r = '0;
      r.link_out = base;
      r.is_base = 1'b1;
      walk.insert(walk.size(), r);
      stk_link[0] = int'(base);
      stk_par[0] = -1;
      top = 1;
      while (top > 0) begin
        top--;
        cur = stk_link[top];
        par = stk_par[top];
        for (int j = 0; j < joints_stored; j++) begin
          if (end_a[j] == cur) nb = int'(end_b[j]);
          else if (end_b[j] == cur) nb = int'(end_a[j]);
          else continue;
          if (nb == par) continue;
          if (walk.size() >= n) begin
            enqueue(status_only(ST_NOT_TREE));
            return;
          end
          r = '0;
          r.slot = LINK_W'(walk.size());
          r.link_out = LINK_W'(nb);
          r.parent_link = LINK_W'(cur);
          r.parent_joint = LINK_W'(j);
          walk.insert(walk.size(), r);
          stk_link[top] = nb;
          stk_par[top] = cur;
          top++;
        end
      end
      walk[walk.size()-1].last = 1'b1;
      foreach (walk[i]) enqueue(walk[i]);
    endfunction

    task report(string what);
      errors++;
      $display("mismatch: %s", what);
    endtask

    task check_record(record_t got);
      record_t want;
      if (expected_records.size() == 0) begin
        report($sformatf("unexpected transaction %p", got));
        return;
      end
      want = expected_records.pop_front();
      if (got.status != want.status) report($sformatf("status %0d want %0d", got.status, want.status));
      if (got.joint_index != want.joint_index)
        report($sformatf("joint_index %0d want %0d", got.joint_index, want.joint_index));
      if (got.pos_offset != want.pos_offset)
        report($sformatf("pos_offset %0d want %0d", got.pos_offset, want.pos_offset));
      if (got.dof_offset != want.dof_offset)
        report($sformatf("dof_offset %0d want %0d", got.dof_offset, want.dof_offset));
      if (got.slot != want.slot) report($sformatf("slot %0d want %0d", got.slot, want.slot));
      if (got.link_out != want.link_out)
        report($sformatf("link_out %0d want %0d", got.link_out, want.link_out));
      if (got.parent_link != want.parent_link)
        report($sformatf("parent_link %0d want %0d", got.parent_link, want.parent_link));
      if (got.parent_joint != want.parent_joint)
        report($sformatf("parent_joint %0d want %0d", got.parent_joint, want.parent_joint));
      if (got.is_base != want.is_base) report($sformatf("is_base %0d want %0d", got.is_base, want.is_base));
      if (got.last != want.last) report($sformatf("last %0d want %0d", got.last, want.last));
    endtask
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CNT_W-1:0]    cfg_data_i;
  logic                start_i;
  logic                busy_o;
  logic                op_i;
  logic [LINK_W-1:0]   first_link_i;
  logic [LINK_W-1:0]   second_link_i;
  logic [SIZE_W-1:0]   joint_pos_coords_i;
  logic [SIZE_W-1:0]   joint_dofs_i;
  logic [LINK_W-1:0]   base_link_i;
  logic                result_valid_o;
  logic [STATUS_W-1:0] status_o;
  logic [LINK_W-1:0]   joint_index_o;
  logic [OFS_W-1:0]    pos_offset_o;
  logic [OFS_W-1:0]    dof_offset_o;
  logic [LINK_W-1:0]   slot_o;
  logic [LINK_W-1:0]   link_out_o;
  logic [LINK_W-1:0]   parent_link_o;
  logic [LINK_W-1:0]   parent_joint_o;
  logic                is_base_o;
  logic                last_o;

  walk_scoreboard sb = new();
  int             idle_pct;
  int             quiet_cycles;
  bit             linked[64];
  int             parent_of[64];
  int             last_grown;

  link_tree_dfs_traversal dut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_data_i, .start_i, .busy_o,
    .op_i, .first_link_i, .second_link_i, .joint_pos_coords_i, .joint_dofs_i,
    .base_link_i, .result_valid_o, .status_o, .joint_index_o, .pos_offset_o,
    .dof_offset_o, .slot_o, .link_out_o, .parent_link_o, .parent_joint_o,
    .is_base_o, .last_o
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      sb.check_record({status_o, joint_index_o, pos_offset_o, dof_offset_o, slot_o,
                       link_out_o, parent_link_o, parent_joint_o, is_base_o, last_o});
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (result_valid_o || (start_i && !busy_o) || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("link_tree_dfs_traversal verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic wait_drained();
    while (sb.expected_records.size() != 0 || busy_o) @(posedge clk_i);
  endtask

  task automatic write_link_count(logic [CNT_W-1:0] value);
    wait_drained();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.link_count = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_item(logic op, logic [LINK_W-1:0] a, logic [LINK_W-1:0] b,
                           logic [SIZE_W-1:0] np, logic [SIZE_W-1:0] nd,
                           logic [LINK_W-1:0] base);
    bit stored;
    if ($urandom_range(99) < idle_pct) repeat ($urandom_range(1, 6)) @(negedge clk_i);
    @(negedge clk_i);
    start_i <= 1'b1;
    op_i <= op;
    first_link_i <= a;
    second_link_i <= b;
    joint_pos_coords_i <= np;
    joint_dofs_i <= nd;
    base_link_i <= base;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    if (op == OP_ADD) begin
      stored = sb.record_add(a, b, np, nd);
      if (stored && linked[a] != linked[b]) begin
        last_grown = linked[a] ? int'(b) : int'(a);
        parent_of[last_grown] = linked[a] ? int'(a) : int'(b);
      end
      if (stored) begin
        linked[a] = 1'b1;
        linked[b] = 1'b1;
      end
    end else begin
      sb.record_walk(base);
    end
    @(negedge clk_i);
    start_i <= 1'b0;
  endtask

  task automatic add_joint(int a, int b);
    send_item(OP_ADD, LINK_W'(a), LINK_W'(b), SIZE_W'($urandom_range(7)),
              SIZE_W'($urandom_range(7)), LINK_W'($urandom_range(63)));
  endtask

  task automatic walk_from(int base);
    send_item(OP_TRAVERSE, LINK_W'($urandom_range(63)), LINK_W'($urandom_range(63)),
              SIZE_W'($urandom_range(7)), SIZE_W'($urandom_range(7)), LINK_W'(base));
  endtask

  // grows the tree by one fresh link, or adds a parallel joint or a self joint
  task automatic grow_tree();
    int fresh, old;
    do old = $urandom_range(63); while (!linked[old]);
    if (sb.joints_stored >= 60) begin
      add_joint(old, old);
    end else if ($urandom_range(9) == 0) begin
      add_joint(old, parent_of[old] < 0 ? old : parent_of[old]);
    end else begin
      fresh = -1;
      for (int k = 0; k < 64; k++) if (!linked[k] && (fresh < 0 || $urandom_range(3) == 0)) fresh = k;
      if (fresh < 0) add_joint(old, old);
      else if ($urandom_range(1)) add_joint(old, fresh);
      else add_joint(fresh, old);
    end
  endtask

  task automatic run_phase(int items, bit lowered);
    int a, b;
    for (int i = 0; i < items; i++) begin
      if (i == items / 2 && $urandom_range(1)) wait_drained();
      if ($urandom_range(99) < 40) begin
        walk_from(lowered ? $urandom_range(7) :
                  ($urandom_range(4) == 0 ? $urandom_range(63) : 0));
      end else if (!lowered) begin
        grow_tree();
      end else begin
        a = $urandom_range(63);
        b = $urandom_range(5, 63);
        if ($urandom_range(3) == 0) add_joint(a, a);
        else if ($urandom_range(1)) add_joint(a, b);
        else add_joint(b, a);
      end
    end
  endtask

  initial begin
    int grand;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    start_i = 1'b0;
    op_i = OP_ADD;
    first_link_i = '0;
    second_link_i = '0;
    joint_pos_coords_i = '0;
    joint_dofs_i = '0;
    base_link_i = '0;
    quiet_cycles = 0;
    idle_pct = 8;
    last_grown = -1;
    foreach (linked[k]) begin
      linked[k] = 1'b0;
      parent_of[k] = -1;
    end
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed part
    add_joint(0, 1);
    walk_from(0);
    write_link_count(CNT_W'(0));
    add_joint(0, 0);
    walk_from(63);
    write_link_count(CNT_W'(64));
    add_joint(63, 63);
    send_item(OP_ADD, LINK_W'(0), LINK_W'(63), SIZE_W'(7), SIZE_W'(7), LINK_W'(0));
    send_item(OP_ADD, LINK_W'(63), LINK_W'(0), SIZE_W'(0), SIZE_W'(0), LINK_W'(63));
    walk_from(63);
    walk_from(0);
    add_joint(0, 21);
    add_joint(42, 63);
    walk_from(21);
    walk_from(42);

    // random part
    idle_pct = 8;
    run_phase(50, 1'b0);
    write_link_count(CNT_W'(5));
    idle_pct = 69;
    run_phase(25, 1'b1);
    write_link_count(7'h7f);
    idle_pct = 0;
    run_phase(55, 1'b0);

    // close a loop, then fill the table
    wait_drained();
    write_link_count(CNT_W'(64));
    if (last_grown >= 0 && parent_of[last_grown] >= 0) begin
      grand = parent_of[parent_of[last_grown]];
      if (grand >= 0) add_joint(last_grown, grand);
    end
    walk_from(0);
    while (sb.joints_stored < 64) add_joint(0, 63);
    add_joint(1, 2);
    walk_from(0);

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_records.size() == 0) begin
      $display("link_tree_dfs_traversal verification clean");
    end else begin
      $display("link_tree_dfs_traversal verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
